@@ rtl/gcdsp_pkg.sv @@
// Shared constants and divider interface types for the greedy change dispenser.
package gcdsp_pkg;

  localparam int unsigned NoteW   = 31;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned DivCntW = 5;

  typedef struct packed {
    logic             start;
    logic [NoteW-1:0] dividend;
    logic [NoteW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NoteW-1:0] quotient;
    logic [NoteW-1:0] remainder;
  } div_rsp_t;

endpackage

@@ rtl/gcdsp_divider.sv @@
// Bit-serial restoring divider that produces one quotient bit per cycle.
module gcdsp_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcdsp_pkg::div_req_t req_i,
  output gcdsp_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = gcdsp_pkg::NoteW;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [gcdsp_pkg::DivCntW-1:0]   step_q, step_d;
  logic [W-1:0]                    rem_q, rem_d;
  logic [W-1:0]                    quot_q, quot_d;
  logic [W-1:0]                    dvsr_q, dvsr_d;
  logic [W:0]                      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvsr_d = dvsr_q;
    trial  = {rem_q, quot_q[W-1]} - {1'b0, dvsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quot_d = req_i.dividend;
      dvsr_d = req_i.divisor;
    end else if (busy_q) begin
      // Shift the next dividend bit into the partial remainder and try a subtract.
      if (!trial[W]) begin
        rem_d  = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[W-2:0], quot_q[W-1]};
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      step_d = step_q + gcdsp_pkg::DivCntW'(1);
      if (step_q == gcdsp_pkg::DivCntW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quot_q <= '0;
      dvsr_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      quot_q <= quot_d;
      dvsr_q <= dvsr_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q;

endmodule

@@ rtl/greedy_change_dispenser_top.sv @@
// Top level of the greedy change dispenser: note registers, sequencer and output register.
//
// The block breaks a requested amount into notes, largest value first. Note values are
// written through the configuration port (index i selects slot i; indexes at or beyond
// NUM_NOTE_SLOTS are ignored, and zero marks an unused slot). For each accepted request
// the block emits one result transaction per nonzero slot in descending value order,
// each carrying the value, the note count, and the amount still left; the final one has
// last_result set. Equal values are each reported, and the later copy gets a count of
// zero. With no slot configured a single closing transaction with value zero and the
// whole amount left is emitted. Requests are handled one at a time. For each note, a
// scan over the slots reads one slot per cycle to find the next largest value, the
// shared bit-serial divider then works out the note count and the amount left, and the
// result is loaded into the output register once that register is free. A new
// request is taken only once the previous one has placed its last result in the output
// register.
module greedy_change_dispenser_top #(
  parameter int unsigned NUM_NOTE_SLOTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gcdsp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [gcdsp_pkg::NoteW-1:0]       cfg_data_i,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gcdsp_pkg::NoteW-1:0]       amount_asked_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gcdsp_pkg::NoteW-1:0]       note_value_o,
  output logic [gcdsp_pkg::NoteW-1:0]       note_count_o,
  output logic [gcdsp_pkg::NoteW-1:0]       amount_left_o,
  output logic                              last_result_o
);

  localparam int unsigned W    = gcdsp_pkg::NoteW;
  localparam int unsigned IdxW = (NUM_NOTE_SLOTS > 1) ? $clog2(NUM_NOTE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_NOTE_SLOTS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDiv,
    StPush
  } state_e;

  // Note value registers.
  logic [W-1:0] note_q [NUM_NOTE_SLOTS];

  state_e                    state_q;
  logic [W-1:0]              rem_q;
  logic [W-1:0]              cnt_q;
  logic [W-1:0]              best_q;
  logic [IdxW-1:0]           best_idx_q;
  logic [IdxW-1:0]           idx_q;
  logic [NUM_NOTE_SLOTS-1:0] used_q;
  logic [CntW-1:0]           remaining_q;
  logic                      out_valid_q;
  logic [W-1:0]              out_value_q;
  logic [W-1:0]              out_count_q;
  logic [W-1:0]              out_left_q;
  logic                      out_last_q;

  logic [W-1:0]              cur_val;
  logic                      take;
  logic [W-1:0]              best_d;
  logic [IdxW-1:0]           best_idx_d;
  logic                      scan_end;
  logic [CntW-1:0]           nonzero_cnt;
  logic                      out_free;

  gcdsp_pkg::div_req_t div_req;
  gcdsp_pkg::div_rsp_t div_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign out_free    = !out_valid_q || out_ready_i;

  // Number of configured notes; a request yields that many results, or one closing result if none.
  always_comb begin
    nonzero_cnt = '0;
    for (int unsigned i = 0; i < NUM_NOTE_SLOTS; i++) begin
      if (note_q[i] != '0) begin
        nonzero_cnt = nonzero_cnt + CntW'(1);
      end
    end
  end

  // One slot per cycle is compared against the best candidate so far. A strict compare
  // keeps the first of several equal values; the others come up on later passes.
  assign cur_val    = note_q[idx_q];
  assign take       = !used_q[idx_q] && (cur_val > best_q);
  assign best_d     = take ? cur_val : best_q;
  assign best_idx_d = take ? idx_q : best_idx_q;
  assign scan_end   = (state_q == StScan) && (idx_q == IdxW'(NUM_NOTE_SLOTS - 1));

  assign div_req.start    = scan_end;
  assign div_req.dividend = rem_q;
  assign div_req.divisor  = best_d;

  gcdsp_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration registers; writes must arrive only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_NOTE_SLOTS; i++) begin
        note_q[i] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < gcdsp_pkg::CfgIdxW'(NUM_NOTE_SLOTS))) begin
      note_q[cfg_index_i[IdxW-1:0]] <= cfg_data_i;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      cnt_q       <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      idx_q       <= '0;
      used_q      <= '0;
      remaining_q <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_count_q <= '0;
      out_left_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // The output register fills from the push state and empties when taken.
      if ((state_q == StPush) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            rem_q       <= amount_asked_i;
            used_q      <= '0;
            remaining_q <= nonzero_cnt;
            best_q      <= '0;
            best_idx_q  <= '0;
            idx_q       <= '0;
            cnt_q       <= '0;
            // With nothing configured the closing result goes out directly.
            state_q     <= (nonzero_cnt == '0) ? StPush : StScan;
          end
        end
        StScan: begin
          best_q     <= best_d;
          best_idx_q <= best_idx_d;
          if (scan_end) begin
            used_q[best_idx_d] <= 1'b1;
            state_q            <= StDiv;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            cnt_q       <= div_rsp.quotient;
            rem_q       <= div_rsp.remainder;
            remaining_q <= remaining_q - CntW'(1);
            state_q     <= StPush;
          end
        end
        StPush: begin
          if (out_free) begin
            out_value_q <= best_q;
            out_count_q <= cnt_q;
            out_left_q  <= rem_q;
            out_last_q  <= (remaining_q == '0);
            best_q      <= '0;
            idx_q       <= '0;
            state_q     <= (remaining_q == '0) ? StIdle : StScan;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign note_value_o  = out_value_q;
  assign note_count_o  = out_count_q;
  assign amount_left_o = out_left_q;
  assign last_result_o = out_last_q;

endmodule

@@ test/tb_greedy_change_dispenser_top.sv @@
// Self-checking testbench for the greedy change dispenser: note-slot setup, requests, result checks.
module tb_greedy_change_dispenser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NoteW   = gcdsp_pkg::NoteW;
  localparam int unsigned CfgIdxW = gcdsp_pkg::CfgIdxW;

  // The number of note slots the block is built with. Writes at or above it are dropped.
  localparam int unsigned NumSlots = 8;
  localparam int unsigned SlotIdxW = $clog2(NumSlots);
  // Largest 31-bit value, used both as an amount and as a note value.
  localparam logic [NoteW-1:0] NoteMax = '1;
  // Cycles without any transaction before the run is declared hung. It must cover one request
  // with all eight slots in use, plus the output stalls on each of its results.
  localparam int unsigned HangLimit = 6000;
  // Quiet time at the end, a bit more than one full request, to catch stray results.
  localparam int unsigned DrainCycles = 500;
  localparam int unsigned MaxPrinted = 40;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned ItemsPerPhase = 10;

  // One result transaction as the block is expected to present it.
  typedef struct packed {
    logic [NoteW-1:0] value;
    logic [NoteW-1:0] count;
    logic [NoteW-1:0] left;
    logic             last;
  } note_result_t;

  // Every block input starts at a known value before any process runs.
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i    = '0;
  logic [NoteW-1:0]   cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [NoteW-1:0]   amount_asked_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [NoteW-1:0]   note_value_o;
  logic [NoteW-1:0]   note_count_o;
  logic [NoteW-1:0]   amount_left_o;
  logic               last_result_o;

  // Our own copy of the note slots, updated whenever a configuration write is accepted.
  logic [NoteW-1:0] note_slot_mirror [NumSlots];
  // Amounts waiting to be offered, and the results owed by requests already accepted.
  logic [NoteW-1:0] pending_amounts_q [$];
  note_result_t     expected_notes_q [$];
  note_result_t     owed_note;

  int unsigned error_count     = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned gap_left        = 0;
  int unsigned stall_left      = 0;
  // Cleared for calm stretches and for the tail of the run, where neither side idles.
  bit          idle_allowed    = 1'b1;

  greedy_change_dispenser_top #(
    .NUM_NOTE_SLOTS(NumSlots)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .amount_asked_i(amount_asked_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .note_value_o  (note_value_o),
    .note_count_o  (note_count_o),
    .amount_left_o (amount_left_o),
    .last_result_o (last_result_o)
  );

  // 20 ns clock period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Prints one line per mismatch (up to a cap so a broken block cannot flood the log) and
  // counts every one of them.
  task automatic report_mismatch(input string what, input logic [NoteW-1:0] got,
                                 input logic [NoteW-1:0] want);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    end
  endtask

  // Appends one amount to the list of requests still to be offered.
  function automatic void add_amount(input logic [NoteW-1:0] amount);
    pending_amounts_q = {pending_amounts_q, amount};
  endfunction

  // Works out the results owed for one request under the current note slots: the nonzero
  // values are ordered largest first, each takes as many notes as fit into what is left,
  // and the remainder moves on. With no value configured a single closing result with
  // value zero carries the whole amount.
  function automatic void plan_dispense(input logic [NoteW-1:0] amount);
    logic [NoteW-1:0] order [NumSlots];
    logic [NoteW-1:0] remaining;
    logic [NoteW-1:0] v;
    note_result_t     r;
    int               n;
    int               i;
    int               j;
    n = 0;
    remaining = amount;
    for (i = 0; i < NumSlots; i++) begin
      v = note_slot_mirror[i];
      if (v != '0) begin
        // Insertion sort; equal values keep slot order, which does not matter since
        // duplicates are reported with identical values anyway.
        j = n;
        while (j > 0 && order[j-1] < v) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
        n++;
      end
    end
    if (n == 0) begin
      r.value = '0;
      r.count = '0;
      r.left  = remaining;
      r.last  = 1'b1;
      expected_notes_q = {expected_notes_q, r};
    end
    for (i = 0; i < n; i++) begin
      r.value   = order[i];
      r.count   = remaining / order[i];
      remaining = remaining % order[i];
      r.left    = remaining;
      r.last    = (i == n - 1);
      expected_notes_q = {expected_notes_q, r};
    end
  endfunction

  // Picks a note value: unused slots, the extremes, duplicates of a slot already set,
  // wide random values and ordinary small denominations.
  function automatic logic [NoteW-1:0] rand_note();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return NoteMax;
      3:       return NoteW'(1);
      4:       return NoteW'($urandom());
      5:       return note_slot_mirror[$urandom_range(0, NumSlots - 1)];
      6:       return NoteW'($urandom_range(1 << 16, 1 << 30));
      default: return NoteW'($urandom_range(1, 2000));
    endcase
  endfunction

  // Picks an amount. Many are exact sums of the configured notes, so the greedy pass
  // often comes out even; the rest are extremes, small values and full-width noise.
  function automatic logic [NoteW-1:0] rand_amount();
    logic [NoteW-1:0] sum;
    int               i;
    sum = '0;
    case ($urandom_range(0, 9))
      0:       return NoteW'($urandom());
      1:       return NoteMax;
      2:       return '0;
      3, 4, 5: begin
        for (i = 0; i < NumSlots; i++) begin
          sum += NoteW'(note_slot_mirror[i] * $urandom_range(0, 3));
        end
        return sum;
      end
      default: return NoteW'($urandom_range(0, 100000));
    endcase
  endfunction

  // Writes one configuration register and waits for its transaction. Slots at or above
  // the slot count must be ignored by the block, so the mirror ignores them too.
  task automatic write_note_reg(input logic [CfgIdxW-1:0] idx, input logic [NoteW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NumSlots) begin
      note_slot_mirror[idx[SlotIdxW-1:0]] = data;
    end
    cfg_writes++;
  endtask

  // Blocks until every queued amount has been taken and every owed result has come back.
  // Every request produces at least one result, so the block is idle at that point.
  task automatic wait_all_dispensed();
    do @(negedge clk_i);
    while (pending_amounts_q.size() != 0 || in_valid_i || expected_notes_q.size() != 0);
  endtask

  // Request driver. When a transaction is accepted its results are predicted right away,
  // so the expectations always line up with the order the block works in. A held valid
  // is never touched; otherwise the driver either idles for a random burst or offers the
  // next amount. Each branch makes exactly one assignment to each signal it drives.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      amount_asked_i <= '0;
      gap_left       <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        plan_dispense(amount_asked_i);
        requests_sent++;
      end
      if (in_valid_i && !in_ready_o) begin
        // Still waiting for the block to take the current request.
      end else if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_amounts_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 5) == 0) begin
        // Start an idle burst that gap_left then counts down.
        in_valid_i <= 1'b0;
        gap_left   <= $urandom_range(0, 17);
      end else begin
        in_valid_i     <= 1'b1;
        amount_asked_i <= pending_amounts_q.pop_front();
      end
    end
  end

  // Result monitor. Each accepted result transaction is checked field by field against
  // the oldest owed result. Ready drops in random bursts, counted down by stall_left.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_notes_q.size() == 0) begin
          report_mismatch("result with no request owing it, value", note_value_o, '0);
        end else begin
          owed_note = expected_notes_q.pop_front();
          if (note_value_o !== owed_note.value) begin
            report_mismatch("note_value", note_value_o, owed_note.value);
          end
          if (note_count_o !== owed_note.count) begin
            report_mismatch("note_count", note_count_o, owed_note.count);
          end
          if (amount_left_o !== owed_note.left) begin
            report_mismatch("amount_left", amount_left_o, owed_note.left);
          end
          if (last_result_o !== owed_note.last) begin
            report_mismatch("last_result", NoteW'(last_result_o), NoteW'(owed_note.last));
          end
          results_checked++;
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(0, 17);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: the run is hung if no transaction of any kind happens for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HangLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no transaction for %0d cycles at %0t", HangLimit, $time);
    $display("FAILED: results differ");
    $finish;
  end

  // Main sequence: reset, a directed part, then random phases. Note slots are only
  // rewritten between phases, once every owed result has been seen.
  initial begin
    int p;
    int k;
    for (k = 0; k < NumSlots; k++) begin
      note_slot_mirror[k] = '0;
    end
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With the slots at their reset value nothing is configured, so every request gets a
    // single closing result that hands back the full amount.
    add_amount('0);
    add_amount(NoteMax);
    add_amount(1);
    add_amount(12345);
    wait_all_dispensed();

    // A common set of denominations written in scrambled slot order, so the block has to
    // do the sorting itself.
    write_note_reg(0, 20);
    write_note_reg(1, 500);
    write_note_reg(2, 1);
    write_note_reg(3, 100);
    write_note_reg(4, 5);
    write_note_reg(5, 200);
    write_note_reg(6, 10);
    write_note_reg(7, 50);
    add_amount(1888);
    add_amount('0);
    add_amount(NoteMax);
    add_amount(499);
    add_amount(3);
    wait_all_dispensed();

    // Extremes: the largest and smallest note values, duplicated values (the second copy
    // must report zero notes), unused slots in between, and writes to indexes beyond the
    // slots, which must change nothing.
    write_note_reg(0, NoteMax);
    write_note_reg(1, 1);
    write_note_reg(2, 100);
    write_note_reg(3, 100);
    write_note_reg(4, '0);
    write_note_reg(5, NoteMax);
    write_note_reg(6, '0);
    write_note_reg(7, 31'h4000_0000);
    write_note_reg(CfgIdxW'(NumSlots), 7);
    write_note_reg('1, 3);
    add_amount(NoteMax);
    add_amount(NoteMax - 1);
    add_amount('0);
    add_amount(250);
    add_amount(31'h4000_0001);
    wait_all_dispensed();

    // A single note value in the last slot only.
    for (k = 0; k < NumSlots - 1; k++) begin
      write_note_reg(CfgIdxW'(k), '0);
    end
    write_note_reg(CfgIdxW'(NumSlots - 1), 7);
    add_amount(6);
    add_amount(7);
    add_amount(NoteMax);
    wait_all_dispensed();

    // Random phases. Each rewrites most slots, sometimes throws in writes to indexes that
    // must be ignored, and then sends a batch of requests. One phase in the middle runs
    // without idling, and so do the final two.
    for (p = 0; p < RandomPhases; p++) begin
      idle_allowed = (p != 3) && (p < RandomPhases - 2);
      for (k = 0; k < NumSlots; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          write_note_reg(CfgIdxW'(k), rand_note());
        end
        if ($urandom_range(0, 5) == 0) begin
          write_note_reg(CfgIdxW'($urandom_range(NumSlots, (1 << CfgIdxW) - 1)),
                         NoteW'($urandom()));
        end
      end
      for (k = 0; k < ItemsPerPhase; k++) begin
        add_amount(rand_amount());
      end
      wait_all_dispensed();
    end

    // Nothing is owed any more; give the block time to show any result it should not.
    repeat (DrainCycles) @(negedge clk_i);
    if (expected_notes_q.size() != 0) begin
      report_mismatch("results never delivered, count", '0, NoteW'(expected_notes_q.size()));
    end

    $display("Covered %0d requests and %0d result transactions over %0d slot writes,",
             requests_sent, results_checked, cfg_writes);
    $display("including empty, duplicate, extreme and ignored-index slot settings.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ greedy_change_dispenser_top.f @@
rtl/gcdsp_pkg.sv
rtl/gcdsp_divider.sv
rtl/greedy_change_dispenser_top.sv
test/tb_greedy_change_dispenser_top.sv
